[hdl/gain_ramp_then_hold_assert.svh]
// Assertion macros shared by the checker.
`ifndef GAIN_RAMP_THEN_HOLD_ASSERT_SVH
`define GAIN_RAMP_THEN_HOLD_ASSERT_SVH

// Clocked implication, disabled while in reset.
`define GRT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// A stalled transfer keeps its signal unchanged into the next cycle.
`define GRT_ASSERT_HOLD(lbl, vld, rdy, sig, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) \
		(vld && !rdy) |=> $stable(sig)) else $error(msg);

`endif

[hdl/grt_pkg.sv]
package grt_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int GAIN_W     = 32;
	localparam int FRAMES_W   = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int PROD_W     = SAMPLE_W + GAIN_W;
	localparam int ROUND_SHIFT = 28;

	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_FRAMES  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RAMP_FRAMES   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_START_GAIN    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_STEP     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CONSTANT_GAIN = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SILENCE       = 3'd5;

	// Unity gain in Q4.28
	localparam logic signed [GAIN_W-1:0] GAIN_UNITY = 32'sh1000_0000;
	localparam logic signed [GAIN_W-1:0] GAIN_MAX   = 32'sh7FFF_FFFF;
	localparam logic signed [GAIN_W-1:0] GAIN_MIN   = 32'sh8000_0000;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

	typedef struct packed {
		logic signed [GAIN_W-1:0] gain;
		logic                     zero;
		logic                     last;
		logic                     err;
	} grt_ctrl_t;

endpackage

[hdl/grt_ctrl.sv]
module grt_ctrl #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [grt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [grt_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                          advance,
	output grt_pkg::grt_ctrl_t            ctrl
);
	import grt_pkg::*;

	localparam int CMP_W = ((COUNT_WIDTH > FRAMES_W) ? COUNT_WIDTH : FRAMES_W) + 1;

	logic [FRAMES_W-1:0]      block_frames_q;
	logic [FRAMES_W-1:0]      ramp_frames_q;
	logic signed [GAIN_W-1:0] start_gain_q;
	logic signed [GAIN_W-1:0] gain_step_q;
	logic signed [GAIN_W-1:0] constant_gain_q;
	logic                     silence_q;

	logic [COUNT_WIDTH-1:0]   frame_index_q;
	logic signed [GAIN_W-1:0] ramp_gain_q;

	logic [FRAMES_W-1:0]      blen;
	logic                     err;
	logic [CMP_W-1:0]         fi_ext;
	logic [CMP_W-1:0]         fi_inc;
	logic                     last;
	logic                     use_ramp;
	logic signed [GAIN_W-1:0] gain_cur;
	logic [GAIN_W:0]          gain_sum;
	logic signed [GAIN_W-1:0] gain_sat;
	logic signed [GAIN_W-1:0] gain_next;
	logic [COUNT_WIDTH-1:0]   frame_next;

	always_comb begin
		blen     = (block_frames_q == '0) ? FRAMES_W'(1) : block_frames_q;
		err      = ramp_frames_q > blen;
		fi_ext   = CMP_W'(frame_index_q);
		fi_inc   = fi_ext + CMP_W'(1);
		last     = fi_inc >= CMP_W'(blen);
		gain_cur = (frame_index_q == '0) ? start_gain_q : ramp_gain_q;
		use_ramp = !err && !silence_q && (fi_ext < CMP_W'(ramp_frames_q));

		gain_sum = {gain_cur[GAIN_W-1], gain_cur} + {gain_step_q[GAIN_W-1], gain_step_q};
		if (gain_sum[GAIN_W] != gain_sum[GAIN_W-1]) begin
			gain_sat = gain_sum[GAIN_W] ? GAIN_MIN : GAIN_MAX;
		end else begin
			gain_sat = gain_sum[GAIN_W-1:0];
		end

		gain_next  = use_ramp ? gain_sat : gain_cur;
		frame_next = last ? '0 : fi_inc[COUNT_WIDTH-1:0];

		ctrl.gain = use_ramp ? gain_cur : constant_gain_q;
		ctrl.zero = err || silence_q;
		ctrl.last = last;
		ctrl.err  = err;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_frames_q  <= FRAMES_W'(1);
			ramp_frames_q   <= '0;
			start_gain_q    <= GAIN_UNITY;
			gain_step_q     <= '0;
			constant_gain_q <= GAIN_UNITY;
			silence_q       <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BLOCK_FRAMES:  block_frames_q  <= cfg_data[FRAMES_W-1:0];
				CFG_RAMP_FRAMES:   ramp_frames_q   <= cfg_data[FRAMES_W-1:0];
				CFG_START_GAIN:    start_gain_q    <= cfg_data[GAIN_W-1:0];
				CFG_GAIN_STEP:     gain_step_q     <= cfg_data[GAIN_W-1:0];
				CFG_CONSTANT_GAIN: constant_gain_q <= cfg_data[GAIN_W-1:0];
				CFG_SILENCE:       silence_q       <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_index_q <= '0;
			ramp_gain_q   <= '0;
		end else if (advance) begin
			frame_index_q <= frame_next;
			ramp_gain_q   <= gain_next;
		end
	end

endmodule

[hdl/grt_scale.sv]
module grt_scale (
	input  logic signed [grt_pkg::SAMPLE_W-1:0] sample,
	input  logic signed [grt_pkg::GAIN_W-1:0]   gain,
	input  logic                               zero,
	output logic signed [grt_pkg::SAMPLE_W-1:0] result
);
	import grt_pkg::*;

	localparam int Q_W = PROD_W - ROUND_SHIFT;
	localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'(1) << (ROUND_SHIFT - 1);

	logic signed [PROD_W-1:0] prod;
	logic signed [PROD_W-1:0] rounded;
	logic [Q_W-1:0]           q;

	// Q1.15 x Q4.28, round half up, floor shift back to Q1.15
	always_comb begin
		prod    = PROD_W'(sample) * PROD_W'(gain);
		rounded = prod + ROUND_BIAS;
		q       = rounded[PROD_W-1:ROUND_SHIFT];
		if (zero) begin
			result = '0;
		end else if (!q[Q_W-1] && (|q[Q_W-2:SAMPLE_W-1])) begin
			result = SAMPLE_MAX;
		end else if (q[Q_W-1] && !(&q[Q_W-2:SAMPLE_W-1])) begin
			result = SAMPLE_MIN;
		end else begin
			result = q[SAMPLE_W-1:0];
		end
	end

endmodule

[hdl/gain_ramp_then_hold.sv]
// Linear gain ramp, then hold.
// Input stream s_axis carries one signed Q1.15 sample per transfer; output
// stream m_axis returns one scaled sample per input, with tlast marking the
// last sample of a block and tuser flagging a ramp longer than the block.
// Gains, ramp length, block length and silence are set through the write
// port (cfg_we, cfg_index, cfg_data); the user must write them only while
// the stream is idle; the block itself does not enforce this. Pipeline: one
// control/input stage, then multiply, round and saturate into the output
// register. Throughput: one sample per cycle while the receiver keeps up;
// the ramp gain and frame counter update on each input transfer.
// Reset clears the frame counter and ramp gain and loads the register
// defaults (block of one, unity gains, no ramp, silence off).
// When the receiver stalls, the output register holds and the input stage
// fills; s_axis_tready then drops until the output is taken, so no sample
// is lost or repeated.
module gain_ramp_then_hold #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [grt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [grt_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [15:0]                   s_axis_tdata,  // [15:0] sample_in
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [15:0]                   m_axis_tdata,  // [15:0] sample_out
	output logic                          m_axis_tlast,  // end_of_block
	output logic                          m_axis_tuser   // [0] config_error
);
	import grt_pkg::*;

	grt_ctrl_t                  ctrl;
	logic                       in_xfer;
	logic                       adv_out;
	logic                       adv_s1;

	logic                       valid_s1;
	logic signed [SAMPLE_W-1:0] sample_s1;
	grt_ctrl_t                  ctrl_s1;

	logic signed [SAMPLE_W-1:0] scaled;

	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] out_sample_q;
	logic                       out_last_q;
	logic                       out_err_q;

	assign adv_out       = !out_valid_q || m_axis_tready;
	assign adv_s1        = !valid_s1 || adv_out;
	assign s_axis_tready = adv_s1;
	assign in_xfer       = s_axis_tvalid && adv_s1;

	grt_ctrl #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.advance  (in_xfer),
		.ctrl     (ctrl)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			sample_s1 <= s_axis_tdata;
			ctrl_s1   <= ctrl;
		end
	end

	grt_scale u_scale (
		.sample(sample_s1),
		.gain  (ctrl_s1.gain),
		.zero  (ctrl_s1.zero),
		.result(scaled)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_out) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out && valid_s1) begin
			out_sample_q <= scaled;
			out_last_q   <= ctrl_s1.last;
			out_err_q    <= ctrl_s1.err;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_sample_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_err_q;

endmodule

[hdl/grt_checker.sv]
`include "gain_ramp_then_hold_assert.svh"

module grt_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_axis_tvalid,
	input logic                          s_axis_tready,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [15:0]                   m_axis_tdata,
	input logic                          m_axis_tlast,
	input logic                          m_axis_tuser
);
	logic [17:0] m_payload;

	assign m_payload = {m_axis_tdata, m_axis_tlast, m_axis_tuser};

	`GRT_ASSERT_HOLD(a_out_valid_hold, m_axis_tvalid, m_axis_tready, m_axis_tvalid, "tvalid dropped")
	`GRT_ASSERT_HOLD(a_out_data_hold, m_axis_tvalid, m_axis_tready, m_payload, "payload changed")
	`GRT_ASSERT(a_err_mutes, (m_axis_tvalid && m_axis_tuser) |-> m_axis_tdata == '0, "error not muted")
	`GRT_ASSERT(a_ready_when_empty, !m_axis_tvalid |-> s_axis_tready, "not ready when empty")

endmodule

bind gain_ramp_then_hold grt_checker u_grt_checker (.*);

[bench/gain_ramp_then_hold_tb.sv]
`timescale 1ns / 1ps

module gain_ramp_then_hold_tb;
	import grt_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_SAMPLES = 2000;
	localparam int SETTLE_CYCLES  = 4;

	typedef struct packed {
		logic [15:0] pcm;
		logic        eob;
		logic        cfg_err;
	} scaled_t;

	class gain_scoreboard;
		logic [15:0]        blk_frames = 16'd1;
		logic [15:0]        ramp_len   = 16'd0;
		logic signed [31:0] ramp_start = GAIN_UNITY;
		logic signed [31:0] ramp_inc   = '0;
		logic signed [31:0] hold_gain  = GAIN_UNITY;
		logic               mute       = 1'b0;
		logic [15:0]        frame_pos  = '0;
		logic signed [31:0] ramp_acc   = '0;
		scaled_t            scaled_q[$];
		int                 mismatches = 0;

		function logic signed [15:0] apply_gain(logic signed [15:0] x, logic signed [31:0] g);
			longint p;
			longint q;
			p = longint'(x) * longint'(g) + (longint'(1) <<< 27);
			q = p >>> 28;
			if (q > 32767)
				return SAMPLE_MAX;
			if (q < -32768)
				return SAMPLE_MIN;
			return q[15:0];
		endfunction

		function logic signed [31:0] sat_add(logic signed [31:0] a, logic signed [31:0] b);
			longint s;
			s = longint'(a) + longint'(b);
			if (s > 64'sd2147483647)
				return GAIN_MAX;
			if (s < -64'sd2147483648)
				return GAIN_MIN;
			return s[31:0];
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				CFG_BLOCK_FRAMES:  blk_frames = val[15:0];
				CFG_RAMP_FRAMES:   ramp_len   = val[15:0];
				CFG_START_GAIN:    ramp_start = val;
				CFG_GAIN_STEP:     ramp_inc   = val;
				CFG_CONSTANT_GAIN: hold_gain  = val;
				CFG_SILENCE:       mute       = val[0];
				default: ;
			endcase
		endfunction

		function void note_sample(logic [15:0] pcm);
			logic [16:0] blen;
			scaled_t     exp_item;
			blen = (blk_frames == 16'd0) ? 17'd1 : {1'b0, blk_frames};
			exp_item.cfg_err = {1'b0, ramp_len} > blen;
			exp_item.pcm = '0;
			if (frame_pos == 16'd0)
				ramp_acc = ramp_start;
			if (!exp_item.cfg_err && !mute) begin
				if (frame_pos < ramp_len) begin
					exp_item.pcm = apply_gain($signed(pcm), ramp_acc);
					ramp_acc = sat_add(ramp_acc, ramp_inc);
				end else begin
					exp_item.pcm = apply_gain($signed(pcm), hold_gain);
				end
			end
			exp_item.eob = ({1'b0, frame_pos} + 17'd1) >= blen;
			frame_pos = exp_item.eob ? 16'd0 : frame_pos + 16'd1;
			scaled_q.push_back(exp_item);
		endfunction

		function void check_result(logic [15:0] pcm, logic eob, logic cfg_err);
			scaled_t exp_item;
			if (scaled_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transfer: data %h last %b user %b", pcm, eob, cfg_err);
				return;
			end
			exp_item = scaled_q.pop_front();
			if (exp_item.pcm !== pcm || exp_item.eob !== eob || exp_item.cfg_err !== cfg_err) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected data %h last %b user %b, got data %h last %b user %b",
						exp_item.pcm, exp_item.eob, exp_item.cfg_err, pcm, eob, cfg_err);
			end
		endfunction

		function int pending();
			return scaled_q.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [15:0]           s_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [15:0]           m_axis_tdata;
	logic                  m_axis_tlast;
	logic                  m_axis_tuser;

	gain_scoreboard sb;
	bit             no_idle = 1'b0;

	gain_ramp_then_hold dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int idle_len();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [31:0] rand_gain();
		case ($urandom_range(0, 9))
			0: return GAIN_MAX;
			1: return GAIN_MIN;
			2: return GAIN_UNITY;
			3, 4, 5: return $urandom;
			default: return 32'($urandom_range(0, 32'h4000_0000)) - 32'h2000_0000;
		endcase
	endfunction

	function automatic logic [31:0] rand_inc();
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return GAIN_MAX;
			2: return GAIN_MIN;
			default: return 32'($urandom_range(0, 32'h0040_0000)) - 32'h0020_0000;
		endcase
	endfunction

	task automatic send_sample(input logic [15:0] pcm);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= pcm;
		do
			@(posedge clk);
		while (!s_axis_tready);
		sb.note_sample(pcm);
	endtask

	// stream idle, every result back, then let the pipeline settle
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		sb.write_reg(idx, val);
	endtask

	task automatic configure(input logic [15:0] bf, input logic [15:0] rf,
			input logic [31:0] sg, input logic [31:0] inc, input logic [31:0] cg, input logic sil);
		drain();
		put_reg(CFG_BLOCK_FRAMES, {16'd0, bf});
		put_reg(CFG_RAMP_FRAMES, {16'd0, rf});
		put_reg(CFG_START_GAIN, sg);
		put_reg(CFG_GAIN_STEP, inc);
		put_reg(CFG_CONSTANT_GAIN, cg);
		put_reg(CFG_SILENCE, {31'd0, sil});
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_phase(output int n);
		int bf;
		int rf;
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			bf = 0;
		else if (r == 1)
			bf = 65535;
		else if (r == 2)
			bf = 1;
		else
			bf = $urandom_range(2, 24);
		r = $urandom_range(0, 9);
		if (r == 0)
			rf = 0;
		else if (r == 1)
			rf = (bf > 65532) ? bf : bf + $urandom_range(1, 3);
		else if (r == 2)
			rf = 65535;
		else if (r == 3)
			rf = bf;
		else
			rf = $urandom_range(0, bf);
		configure(16'(bf), 16'(rf), rand_gain(), rand_inc(), rand_gain(), $urandom_range(0, 7) == 0);
		no_idle = ($urandom_range(0, 5) == 0);
		n = $urandom_range(20, 120);
		for (int i = 0; i < n; i++)
			send_sample(16'($urandom));
	endtask

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata, m_axis_tlast, m_axis_tuser);
	end

	initial begin
		int gap;
		m_axis_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = idle_len();
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		int sent;
		int n;
		sb = new;
		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_index     <= CFG_BLOCK_FRAMES;
		cfg_data      <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: unity gain, one-sample blocks
		send_sample(16'h7FFF);
		send_sample(16'h8000);
		send_sample(16'h0001);

		// zero block length, max hold gain saturates
		configure(16'd0, 16'd0, GAIN_UNITY, '0, GAIN_MAX, 1'b0);
		send_sample(16'h7FFF);
		send_sample(16'h8000);
		send_sample(16'h0001);

		// ramp accumulator saturates high
		configure(16'd4, 16'd4, 32'h7000_0000, GAIN_MAX, GAIN_MIN, 1'b0);
		send_sample(16'h0001);
		send_sample(16'h0001);
		send_sample(16'h7FFF);
		send_sample(16'h8000);

		// ramp accumulator saturates low
		configure(16'd3, 16'd3, GAIN_MIN, GAIN_MIN, GAIN_UNITY, 1'b0);
		send_sample(16'h0001);
		send_sample(16'h7FFF);
		send_sample(16'h8000);

		// half gain: round half up, falling ramp then negative hold gain
		configure(16'd6, 16'd3, 32'h0800_0000, 32'hFC00_0000, GAIN_MIN, 1'b0);
		send_sample(16'h0001);
		send_sample(16'hFFFF);
		send_sample(16'h8000);
		send_sample(16'h7FFF);
		send_sample(16'h8000);
		send_sample(16'h0003);

		// ramp longer than block, with silence too: error wins
		configure(16'd3, 16'd5, GAIN_UNITY, '0, GAIN_UNITY, 1'b1);
		send_sample(16'h1234);
		send_sample(16'h8000);

		configure(16'd8, 16'd2, GAIN_UNITY, '0, GAIN_UNITY, 1'b1);
		send_sample(16'h7FFF);
		send_sample(16'h8000);

		// block shortened below the current position
		configure(16'd2, 16'd2, GAIN_UNITY, '0, GAIN_UNITY, 1'b0);
		send_sample(16'h4000);
		send_sample(16'hC000);

		sent = 0;
		while (sent < RANDOM_SAMPLES) begin
			random_phase(n);
			sent += n;
		end
		no_idle = 1'b0;

		drain();
		repeat (8) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
